// File: design/flkvs_pkg.sv
// Shared types, codes and record helpers for the flash log key-value store.
`timescale 1ns / 1ps
`default_nettype none

package flkvs_pkg;

   // Request function codes
   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_FORMAT = 2'd2;
   localparam logic [1:0] FUNC_RESCAN = 2'd3;

   // Response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // Log write data select
   localparam logic [1:0] LOGW_NONE = 2'd0;
   localparam logic [1:0] LOGW_ONES = 2'd1;
   localparam logic [1:0] LOGW_COPY = 2'd2;
   localparam logic [1:0] LOGW_ITEM = 2'd3;

   // Record format
   localparam logic [15:0] REC_MAGIC = 16'h4853;
   localparam logic [15:0] CHECK_XOR = 16'hA5A5;
   localparam int unsigned REC_W     = 64;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] item_key;
      logic [15:0] item_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] read_value;
      logic        compacted;
   } rsp_item_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       take_item;
      logic       idx_clr;
      logic       idx_inc;
      logic       slot_clr;
      logic       slot_inc;
      logic       used_clr;
      logic       used_inc;
      logic       next_clr;
      logic       next_inc;
      logic       next_from_idx;
      logic       log_rd;
      logic [1:0] log_wsel;
      logic       cache_rd;
      logic       cache_wr;
      logic       srch_item;
      logic       srch_log;
      logic       rval_load;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_comp;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic idx_end;
      logic slot_at_used;
      logic key_match;
      logic val_match;
      logic log_empty;
      logic log_valid;
      logic cache_full;
      logic log_full;
   } dp_sts_type;

   function automatic logic [REC_W-1:0] make_record(input logic [15:0] k,
                                                    input logic [15:0] v);
      make_record = {REC_MAGIC, k ^ v ^ CHECK_XOR, v, k};
   endfunction

endpackage

`default_nettype wire

// File: design/flkvs_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module flkvs_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// File: design/flkvs_dp.sv
// Datapath: log and cache memories, walk counters, search and response registers.
`timescale 1ns / 1ps
`default_nettype none

module flkvs_dp #(
   parameter int unsigned CACHE_SLOTS = 16,
   parameter int unsigned LOG_DEPTH   = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire flkvs_pkg::req_item_type req_item,
   input  wire flkvs_pkg::ctl_cmd_type  cmd,
   output flkvs_pkg::dp_sts_type       sts,
   output flkvs_pkg::rsp_item_type     rsp_item
);
   import flkvs_pkg::*;

   localparam int unsigned CW = $clog2(CACHE_SLOTS + 1);
   localparam int unsigned LW = $clog2(LOG_DEPTH + 1);
   localparam int unsigned CA = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
   localparam int unsigned LA = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

   logic [LW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    slot_ff, slot_in;
   logic [CW-1:0]    used_ff, used_in;
   logic [LW-1:0]    next_ff, next_in;
   logic [15:0]      item_key_ff, item_val_ff;
   logic [15:0]      srch_key_ff, srch_val_ff;
   logic [15:0]      rval_ff;
   rsp_item_type     rsp_ff;

   logic             log_we;
   logic [LA-1:0]    log_waddr;
   logic [REC_W-1:0] log_wdata;
   logic [REC_W-1:0] log_rdata;
   logic [15:0]      ckey_rd, cval_rd;
   logic [15:0]      lk, lv, lc, lm;

   // Counter next values
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      slot_in = slot_ff;
      if (cmd.slot_clr) begin
         slot_in = '0;
      end else if (cmd.slot_inc) begin
         slot_in = slot_ff + 1'b1;
      end
      used_in = used_ff;
      if (cmd.used_clr) begin
         used_in = '0;
      end else if (cmd.used_inc) begin
         used_in = used_ff + 1'b1;
      end
      next_in = next_ff;
      if (cmd.next_clr) begin
         next_in = '0;
      end else if (cmd.next_from_idx) begin
         next_in = idx_ff;
      end else if (cmd.next_inc) begin
         next_in = next_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         slot_ff <= '0;
         used_ff <= '0;
         next_ff <= '0;
      end else begin
         idx_ff  <= idx_in;
         slot_ff <= slot_in;
         used_ff <= used_in;
         next_ff <= next_in;
      end
   end

   // Item, search key and response payload registers
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_key_ff <= req_item.item_key;
         item_val_ff <= req_item.item_value;
         srch_key_ff <= req_item.item_key;
         srch_val_ff <= req_item.item_value;
      end else if (cmd.srch_item) begin
         srch_key_ff <= item_key_ff;
         srch_val_ff <= item_val_ff;
      end else if (cmd.srch_log) begin
         srch_key_ff <= lk;
         srch_val_ff <= lv;
      end
      if (cmd.take_item) begin
         rval_ff <= '0;
      end else if (cmd.rval_load) begin
         rval_ff <= cval_rd;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status     <= cmd.rsp_status;
         rsp_ff.read_value <= rval_ff;
         rsp_ff.compacted  <= cmd.rsp_comp;
      end
   end

   // Log write port
   always_comb begin
      log_we    = (cmd.log_wsel != LOGW_NONE);
      log_waddr = idx_ff[LA-1:0];
      log_wdata = '1;
      case (cmd.log_wsel)
         LOGW_COPY: log_wdata = make_record(ckey_rd, cval_rd);
         LOGW_ITEM: begin
            log_waddr = next_ff[LA-1:0];
            log_wdata = make_record(item_key_ff, item_val_ff);
         end
         default:   log_wdata = '1;
      endcase
   end

   flkvs_ram #(.WIDTH(REC_W), .DEPTH(LOG_DEPTH)) u_log (
      .clock (clock),
      .we    (log_we),
      .waddr (log_waddr),
      .wdata (log_wdata),
      .re    (cmd.log_rd),
      .raddr (idx_ff[LA-1:0]),
      .rdata (log_rdata)
   );

   flkvs_ram #(.WIDTH(16), .DEPTH(CACHE_SLOTS)) u_ckey (
      .clock (clock),
      .we    (cmd.cache_wr),
      .waddr (slot_ff[CA-1:0]),
      .wdata (srch_key_ff),
      .re    (cmd.cache_rd),
      .raddr (slot_ff[CA-1:0]),
      .rdata (ckey_rd)
   );

   flkvs_ram #(.WIDTH(16), .DEPTH(CACHE_SLOTS)) u_cval (
      .clock (clock),
      .we    (cmd.cache_wr),
      .waddr (slot_ff[CA-1:0]),
      .wdata (srch_val_ff),
      .re    (cmd.cache_rd),
      .raddr (slot_ff[CA-1:0]),
      .rdata (cval_rd)
   );

   // Record fields and status flags
   assign lk = log_rdata[15:0];
   assign lv = log_rdata[31:16];
   assign lc = log_rdata[47:32];
   assign lm = log_rdata[63:48];

   assign sts.idx_end      = (idx_ff == LW'(LOG_DEPTH));
   assign sts.slot_at_used = (slot_ff == used_ff);
   assign sts.key_match    = (ckey_rd == srch_key_ff);
   assign sts.val_match    = (cval_rd == srch_val_ff);
   assign sts.log_empty    = (log_rdata == '1);
   assign sts.log_valid    = (lm == REC_MAGIC) && (lc == (lk ^ lv ^ CHECK_XOR));
   assign sts.cache_full   = (used_ff == CW'(CACHE_SLOTS));
   assign sts.log_full     = (next_ff == LW'(LOG_DEPTH));

   assign rsp_item = rsp_ff;

   // Checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(CACHE_SLOTS))
      else $error("cache fill count past slot count");

   a_next_bound: assert property (@(posedge clock) disable iff (reset)
      next_ff <= LW'(LOG_DEPTH))
      else $error("next record past log depth");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.log_wsel == LOGW_ITEM) |-> !sts.log_full)
      else $error("append into a full log");

   a_cache_wr_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.cache_wr |-> (slot_ff <= used_ff) && (slot_ff < CW'(CACHE_SLOTS)))
      else $error("cache write outside filled range");

endmodule

`default_nettype wire

// File: design/flkvs_ctrl.sv
// Controller: sequences erase, scan, lookup, append and compaction.
`timescale 1ns / 1ps
`default_nettype none

module flkvs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_func,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output flkvs_pkg::ctl_cmd_type    cmd,
   input  wire flkvs_pkg::dp_sts_type sts
);
   import flkvs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ERASE, S_SC_RD, S_SC_CHK, S_F_RD, S_F_CHK,
      S_APPEND, S_CP_RD, S_CP_WR, S_DONE
   } state_type;

   typedef enum logic [1:0] {ET_RESET, ET_FORMAT, ET_COMPACT} erase_tgt_type;

   state_type     state_ff, state_in;
   erase_tgt_type tgt_ff, tgt_in;
   logic [1:0]    op_ff, op_in;
   logic [1:0]    status_ff, status_in;
   logic          scan_ctx_ff, scan_ctx_in;
   logic          init_ff, init_in;
   logic          comp_ff, comp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      tgt_in       = tgt_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      scan_ctx_in  = scan_ctx_ff;
      init_in      = init_ff;
      comp_in      = comp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.log_wsel = LOGW_NONE;
      cmd.rsp_status = status_ff;
      cmd.rsp_comp   = comp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.take_item = 1'b1;
               op_in         = req_func;
               comp_in       = 1'b0;
               status_in     = ST_OK;
               case (req_func)
                  FUNC_FORMAT: begin
                     cmd.idx_clr = 1'b1;
                     tgt_in      = ET_FORMAT;
                     state_in    = S_ERASE;
                  end
                  FUNC_RESCAN: begin
                     cmd.used_clr = 1'b1;
                     cmd.idx_clr  = 1'b1;
                     cmd.next_clr = 1'b1;
                     state_in     = S_SC_RD;
                  end
                  default: begin
                     if (init_ff) begin
                        cmd.slot_clr = 1'b1;
                        scan_ctx_in  = 1'b0;
                        state_in     = S_F_RD;
                     end else begin
                        cmd.used_clr = 1'b1;
                        cmd.idx_clr  = 1'b1;
                        cmd.next_clr = 1'b1;
                        state_in     = S_SC_RD;
                     end
                  end
               endcase
            end
         end

         // One erased record per cycle
         S_ERASE: begin
            if (sts.idx_end) begin
               unique case (tgt_ff)
                  ET_FORMAT: begin
                     cmd.used_clr = 1'b1;
                     cmd.next_clr = 1'b1;
                     init_in      = 1'b1;
                     state_in     = S_DONE;
                  end
                  ET_COMPACT: begin
                     cmd.idx_clr  = 1'b1;
                     cmd.slot_clr = 1'b1;
                     state_in     = S_CP_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end else begin
               cmd.log_wsel = LOGW_ONES;
               cmd.idx_inc  = 1'b1;
            end
         end

         // Scan: fetch a record
         S_SC_RD: begin
            if (sts.idx_end) begin
               cmd.next_from_idx = 1'b1;
               init_in           = 1'b1;
               if (op_ff == FUNC_RESCAN) begin
                  state_in = S_DONE;
               end else begin
                  cmd.srch_item = 1'b1;
                  cmd.slot_clr  = 1'b1;
                  scan_ctx_in   = 1'b0;
                  state_in      = S_F_RD;
               end
            end else begin
               cmd.log_rd = 1'b1;
               state_in   = S_SC_CHK;
            end
         end

         // Scan: classify the record
         S_SC_CHK: begin
            if (sts.log_empty) begin
               cmd.next_from_idx = 1'b1;
               init_in           = 1'b1;
               if (op_ff == FUNC_RESCAN) begin
                  state_in = S_DONE;
               end else begin
                  cmd.srch_item = 1'b1;
                  cmd.slot_clr  = 1'b1;
                  scan_ctx_in   = 1'b0;
                  state_in      = S_F_RD;
               end
            end else if (sts.log_valid) begin
               cmd.srch_log = 1'b1;
               cmd.slot_clr = 1'b1;
               scan_ctx_in  = 1'b1;
               state_in     = S_F_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SC_RD;
            end
         end

         // Cache walk: fetch a slot or handle a miss
         S_F_RD: begin
            if (sts.slot_at_used) begin
               if (scan_ctx_ff) begin
                  if (sts.cache_full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     cmd.cache_wr = 1'b1;
                     cmd.used_inc = 1'b1;
                     cmd.idx_inc  = 1'b1;
                     state_in     = S_SC_RD;
                  end
               end else if (op_ff == FUNC_READ) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end else if (sts.cache_full) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  cmd.cache_wr = 1'b1;
                  cmd.used_inc = 1'b1;
                  state_in     = S_APPEND;
               end
            end else begin
               cmd.cache_rd = 1'b1;
               state_in     = S_F_CHK;
            end
         end

         // Cache walk: compare the slot key
         S_F_CHK: begin
            if (sts.key_match) begin
               if (scan_ctx_ff) begin
                  cmd.cache_wr = 1'b1;
                  cmd.idx_inc  = 1'b1;
                  state_in     = S_SC_RD;
               end else if (op_ff == FUNC_READ) begin
                  cmd.rval_load = 1'b1;
                  state_in      = S_DONE;
               end else if (sts.val_match) begin
                  state_in = S_DONE;
               end else begin
                  cmd.cache_wr = 1'b1;
                  state_in     = S_APPEND;
               end
            end else begin
               cmd.slot_inc = 1'b1;
               state_in     = S_F_RD;
            end
         end

         // Append the new record, compacting once when the log is full; if it is still full, skip the append
         S_APPEND: begin
            if (sts.log_full) begin
               if (comp_ff) begin
                  state_in = S_DONE;
               end else begin
                  comp_in     = 1'b1;
                  cmd.idx_clr = 1'b1;
                  tgt_in      = ET_COMPACT;
                  state_in    = S_ERASE;
               end
            end else begin
               cmd.log_wsel = LOGW_ITEM;
               cmd.next_inc = 1'b1;
               state_in     = S_DONE;
            end
         end

         // Compaction: copy cache slots into the fresh log
         S_CP_RD: begin
            if (sts.slot_at_used || sts.idx_end) begin
               cmd.next_from_idx = 1'b1;
               state_in          = S_APPEND;
            end else begin
               cmd.cache_rd = 1'b1;
               state_in     = S_CP_WR;
            end
         end

         S_CP_WR: begin
            cmd.log_wsel = LOGW_COPY;
            cmd.idx_inc  = 1'b1;
            cmd.slot_inc = 1'b1;
            state_in     = S_CP_RD;
         end

         // Hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ERASE;
         tgt_ff       <= ET_RESET;
         op_ff        <= FUNC_READ;
         status_ff    <= ST_OK;
         scan_ctx_ff  <= 1'b0;
         init_ff      <= 1'b0;
         comp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tgt_ff       <= tgt_in;
         op_ff        <= op_in;
         status_ff    <= status_in;
         scan_ctx_ff  <= scan_ctx_in;
         init_ff      <= init_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: design/flash_log_key_value_store.sv
// Top level: EEPROM emulation key-value store over a flash record log.
// A request walks the filled cache slots by key: a read hit or unchanged write ends at the
// match, a read miss after the last slot, a changed or new-key write then appends a record;
// the next item can be taken in the cycle after the result is loaded. A scan reads each record
// and walks the cache per valid one; compaction erases the log and copies each entry back.
// After reset a clearing pass erases the log; no item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module flash_log_key_value_store #(
   parameter int unsigned CACHE_SLOTS = 16,
   parameter int unsigned LOG_DEPTH   = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire flkvs_pkg::req_item_type req_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output flkvs_pkg::rsp_item_type      rsp_item
);
   import flkvs_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   flkvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_item.func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   flkvs_dp #(.CACHE_SLOTS(CACHE_SLOTS), .LOG_DEPTH(LOG_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for the flash log key-value store: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb;
   import flkvs_pkg::*;

   localparam int SLOTS      = 16;
   localparam int DEPTH      = 256;
   localparam int IDLE_LIMIT = 60000;
   localparam logic [63:0] ERASED = 64'hFFFF_FFFF_FFFF_FFFF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   flash_log_key_value_store dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor state
   logic [15:0] mdl_keys [SLOTS];
   logic [15:0] mdl_vals [SLOTS];
   int          mdl_used;
   logic [63:0] mdl_log [DEPTH];
   int          mdl_next;
   bit          mdl_init;

   rsp_item_type pending_rsp [$];
   int  fail_count;
   int  burst_left;
   int  hold_ticket;
   logic [15:0] key_pool [20];
   logic [15:0] val_pool [4];

   function automatic logic [63:0] rec_of(logic [15:0] k, logic [15:0] v);
      return {16'h4853, k ^ v ^ 16'hA5A5, v, k};
   endfunction

   function automatic int slot_of(logic [15:0] k);
      for (int i = 0; i < mdl_used; i++)
         if (mdl_keys[i] == k) return i;
      return -1;
   endfunction

   function automatic bit cache_store(logic [15:0] k, logic [15:0] v);
      int s;
      s = slot_of(k);
      if (s >= 0) begin
         mdl_vals[s] = v;
         return 1'b1;
      end
      if (mdl_used >= SLOTS) return 1'b0;
      mdl_keys[mdl_used] = k;
      mdl_vals[mdl_used] = v;
      mdl_used++;
      return 1'b1;
   endfunction

   // Walk the log into the cache; returns 0 when the cache overflows
   function automatic bit scan_into_cache();
      logic [63:0] r;
      mdl_used = 0;
      mdl_next = 0;
      for (int i = 0; i < DEPTH; i++) begin
         r = mdl_log[i];
         if (r == ERASED) begin
            mdl_next = i;
            return 1'b1;
         end
         if (r[63:48] == 16'h4853 && r[47:32] == (r[15:0] ^ r[31:16] ^ 16'hA5A5))
            if (!cache_store(r[15:0], r[31:16])) return 1'b0;
      end
      mdl_next = DEPTH;
      return 1'b1;
   endfunction

   function automatic bit ready_store();
      if (mdl_init) return 1'b1;
      if (!scan_into_cache()) return 1'b0;
      mdl_init = 1'b1;
      return 1'b1;
   endfunction

   function automatic rsp_item_type kv_predict(req_item_type r);
      rsp_item_type o;
      int s;
      o = '0;
      o.status = ST_OK;
      case (r.func)
         FUNC_READ: begin
            if (!ready_store()) o.status = ST_FULL;
            else begin
               s = slot_of(r.item_key);
               if (s < 0) o.status = ST_NOT_FOUND;
               else o.read_value = mdl_vals[s];
            end
         end
         FUNC_WRITE: begin
            if (!ready_store()) o.status = ST_FULL;
            else begin
               s = slot_of(r.item_key);
               if (!(s >= 0 && mdl_vals[s] == r.item_value)) begin
                  if (!cache_store(r.item_key, r.item_value)) o.status = ST_FULL;
                  else begin
                     // log full: erase, rewrite cache, then append
                     if (mdl_next >= DEPTH) begin
                        for (int i = 0; i < DEPTH; i++) mdl_log[i] = ERASED;
                        for (int i = 0; i < mdl_used; i++)
                           mdl_log[i] = rec_of(mdl_keys[i], mdl_vals[i]);
                        mdl_next = mdl_used;
                        o.compacted = 1'b1;
                     end
                     if (mdl_next < DEPTH) begin
                        mdl_log[mdl_next] = rec_of(r.item_key, r.item_value);
                        mdl_next++;
                     end
                  end
               end
            end
         end
         FUNC_FORMAT: begin
            for (int i = 0; i < DEPTH; i++) mdl_log[i] = ERASED;
            mdl_used = 0;
            mdl_next = 0;
            mdl_init = 1'b1;
         end
         default: begin
            if (scan_into_cache()) mdl_init = 1'b1;
            else o.status = ST_FULL;
         end
      endcase
      return o;
   endfunction

   // Send one item, with bursts and random gaps between them
   task automatic send_req(logic [1:0] f, logic [15:0] k, logic [15:0] v);
      req_item_type it;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      it.func = f;
      it.item_key = k;
      it.item_value = v;
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(kv_predict(it));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result item");
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_item.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.read_value !== e.read_value) begin
               $error("read_value exp %h got %h", e.read_value, rsp_item.read_value);
               fail_count++;
            end
            if (rsp_item.compacted !== e.compacted) begin
               $error("compacted exp %0d got %0d", e.compacted, rsp_item.compacted);
               fail_count++;
            end
         end
      end
   end

   // Receiver stall pattern, plus long hold-offs on request
   int seen_ticket = 0;
   int hold_left = 0;
   int pat_left = 0;
   int pat_mode = 0;
   int pat_phase = 0;
   always @(posedge clock) begin
      if (hold_ticket != seen_ticket) begin
         seen_ticket = hold_ticket;
         hold_left = 400;
      end
      if (pat_left == 0) begin
         pat_left = $urandom_range(16, 128);
         pat_mode = $urandom_range(0, 2);
      end
      pat_left--;
      pat_phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else case (pat_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 4);
         default: rsp_stall <= (pat_phase % 5) < 2;
      endcase
   end

   // Watchdog on cycles with no accepted item and no taken result
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic test_first_read();
      send_req(FUNC_READ, 16'h1234, 16'h0000);
      send_req(FUNC_WRITE, 16'h0000, 16'h0000);
      send_req(FUNC_WRITE, 16'hFFFF, 16'hFFFF);
      send_req(FUNC_READ, 16'h0000, 16'hFFFF);
      send_req(FUNC_READ, 16'hFFFF, 16'h0000);
   endtask

   task automatic test_unchanged_write();
      send_req(FUNC_WRITE, 16'hFFFF, 16'hFFFF);
      send_req(FUNC_WRITE, 16'hFFFF, 16'h5A5A);
      send_req(FUNC_READ, 16'hFFFF, 16'h0000);
      send_req(FUNC_READ, 16'hABCD, 16'h0000);
   endtask

   task automatic test_rescan();
      send_req(FUNC_RESCAN, 16'h0000, 16'h0000);
      send_req(FUNC_READ, 16'hFFFF, 16'h0000);
      send_req(FUNC_READ, 16'h0000, 16'h0000);
   endtask

   task automatic test_cache_full();
      send_req(FUNC_FORMAT, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < SLOTS + 1; i++)
         send_req(FUNC_WRITE, 16'(16'h0100 + i), 16'(16'h8000 + i));
      send_req(FUNC_READ, 16'(16'h0100 + SLOTS), 16'h0000);
      send_req(FUNC_RESCAN, 16'h0000, 16'h0000);
   endtask

   task automatic test_compaction();
      send_req(FUNC_FORMAT, 16'h0000, 16'h0000);
      for (int i = 0; i < DEPTH + 4; i++)
         send_req(FUNC_WRITE, 16'h0042, i[15:0]);
      send_req(FUNC_READ, 16'h0042, 16'h0000);
   endtask

   task automatic test_backpressure();
      hold_ticket++;
      for (int i = 0; i < 8; i++)
         send_req(FUNC_READ, 16'h0042, 16'h0000);
      drain();
   endtask

   function automatic logic [1:0] pick_func();
      int d;
      d = $urandom_range(0, 99);
      if (d < 45) return FUNC_READ;
      if (d < 95) return FUNC_WRITE;
      if (d < 96) return FUNC_FORMAT;
      return FUNC_RESCAN;
   endfunction

   task automatic test_random();
      for (int n = 0; n < 750; n++) begin
         if (n % 150 == 0) begin
            for (int i = 0; i < 20; i++) key_pool[i] = 16'($urandom_range(0, 16'hFFFF));
            key_pool[0] = 16'h0000;
            key_pool[1] = 16'hFFFF;
            for (int i = 0; i < 4; i++) val_pool[i] = 16'($urandom_range(0, 16'hFFFF));
         end
         if (n == 375) drain();
         send_req(pick_func(),
                  ($urandom_range(0, 15) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 19)],
                  ($urandom_range(0, 1) == 0) ? 16'($urandom) : val_pool[$urandom_range(0, 3)]);
      end
   endtask

   initial begin
      fail_count = 0;
      burst_left = 0;
      hold_ticket = 0;
      mdl_used = 0;
      mdl_next = 0;
      mdl_init = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         mdl_keys[i] = '0;
         mdl_vals[i] = '0;
      end
      for (int i = 0; i < DEPTH; i++) mdl_log[i] = ERASED;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_read();
      test_unchanged_write();
      test_rescan();
      test_cache_full();
      test_compaction();
      test_backpressure();
      test_random();
      drain();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
